// File: hdl/bel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bel_pkg
// Shared constants, types and character tables for the button event parser.
// ----------------------------------------------------------------------------
package bel_pkg;

    localparam int LINE_BYTES = 256;
    localparam int LEN_W      = $clog2(LINE_BYTES);
    localparam int HDR_LEN    = 11;
    localparam int IN_W       = 8;
    localparam int OUT_W      = 8;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    localparam logic [1:0] BTN_LEFT   = 2'd0;
    localparam logic [1:0] BTN_CENTER = 2'd1;
    localparam logic [1:0] BTN_RIGHT  = 2'd2;

    localparam logic [1:0] VERDICT_NONE = 2'd0;
    localparam logic [1:0] VERDICT_DOWN = 2'd1;
    localparam logic [1:0] VERDICT_HELD = 2'd2;
    localparam logic [1:0] VERDICT_UP   = 2'd3;

    localparam logic [LEN_W-1:0] LAST_POS = LEN_W'(LINE_BYTES - 1);

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             matching;
        logic [1:0]       button;
        logic [1:0]       verdict;
    } t_line;

    typedef struct packed {
        logic line_ended;
        logic event_applied;
        logic overflow;
    } t_flags;

    localparam t_line LINE_CLEAR = '{len: '0, matching: 1'b1,
                                     button: BTN_LEFT, verdict: VERDICT_NONE};

    // "EVT BUTTON "
    function automatic logic [7:0] hdr_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "E";
            4'd1:    ch = "V";
            4'd2:    ch = "T";
            4'd3:    ch = " ";
            4'd4:    ch = "B";
            4'd5:    ch = "U";
            4'd6:    ch = "T";
            4'd7:    ch = "T";
            4'd8:    ch = "O";
            4'd9:    ch = "N";
            4'd10:   ch = " ";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] btn_char(input logic [1:0] id, input logic [2:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (id)
            BTN_LEFT: begin
                case (idx)
                    3'd0:    ch = "L";
                    3'd1:    ch = "E";
                    3'd2:    ch = "F";
                    3'd3:    ch = "T";
                    3'd4:    ch = " ";
                    default: ch = 8'h00;
                endcase
            end
            BTN_CENTER: begin
                case (idx)
                    3'd0:    ch = "C";
                    3'd1:    ch = "E";
                    3'd2:    ch = "N";
                    3'd3:    ch = "T";
                    3'd4:    ch = "E";
                    3'd5:    ch = "R";
                    3'd6:    ch = " ";
                    default: ch = 8'h00;
                endcase
            end
            BTN_RIGHT: begin
                case (idx)
                    3'd0:    ch = "R";
                    3'd1:    ch = "I";
                    3'd2:    ch = "G";
                    3'd3:    ch = "H";
                    3'd4:    ch = "T";
                    3'd5:    ch = " ";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [LEN_W-1:0] btn_len(input logic [1:0] id);
        logic [LEN_W-1:0] n;
        case (id)
            BTN_LEFT:   n = LEN_W'(5);
            BTN_CENTER: n = LEN_W'(7);
            BTN_RIGHT:  n = LEN_W'(6);
            default:    n = '0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] state_char(input logic [1:0] v, input logic [1:0] idx);
        logic [7:0] ch;
        ch = 8'h00;
        case (v)
            VERDICT_DOWN: begin
                case (idx)
                    2'd0:    ch = "D";
                    2'd1:    ch = "O";
                    2'd2:    ch = "W";
                    2'd3:    ch = "N";
                    default: ch = 8'h00;
                endcase
            end
            VERDICT_HELD: begin
                case (idx)
                    2'd0:    ch = "H";
                    2'd1:    ch = "E";
                    2'd2:    ch = "L";
                    2'd3:    ch = "D";
                    default: ch = 8'h00;
                endcase
            end
            VERDICT_UP: begin
                case (idx)
                    2'd0:    ch = "U";
                    2'd1:    ch = "P";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [LEN_W-1:0] state_len(input logic [1:0] v);
        logic [LEN_W-1:0] n;
        case (v)
            VERDICT_DOWN: n = LEN_W'(4);
            VERDICT_HELD: n = LEN_W'(4);
            VERDICT_UP:   n = LEN_W'(2);
            default:      n = '0;
        endcase
        return n;
    endfunction

endpackage

// File: hdl/bel_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bel_match
// Per-byte next-state logic: pattern match step, line close and overflow.
// ----------------------------------------------------------------------------
module bel_match (
    input  logic [7:0]     i_byte,
    input  bel_pkg::t_line i_line,
    input  logic [2:0]     i_mask,
    output bel_pkg::t_line o_line,
    output logic [2:0]     o_mask,
    output bel_pkg::t_flags o_flags
);
    import bel_pkg::*;

    logic             is_term;
    logic [LEN_W-1:0] p;
    logic [LEN_W-1:0] s;
    logic [LEN_W-1:0] btn_off;
    logic [LEN_W-1:0] st_off;
    logic             line_hit;
    logic [2:0]       bit_sel;

    assign is_term = (i_byte == CHAR_LF) || (i_byte == CHAR_CR);
    assign p       = i_line.len;
    // start of the state word
    assign s       = LEN_W'(HDR_LEN) + btn_len(i_line.button);
    assign btn_off = p - LEN_W'(HDR_LEN);
    assign st_off  = p - s;
    assign bit_sel = 3'b001 << i_line.button;

    assign line_hit = i_line.matching && (i_line.verdict != VERDICT_NONE) &&
                      (i_line.len >= s + state_len(i_line.verdict));

    always_comb begin
        o_line  = i_line;
        o_mask  = i_mask;
        o_flags = '0;
        if (is_term) begin
            if (i_line.len != '0) begin
                o_flags.line_ended = 1'b1;
                if (line_hit) begin
                    o_flags.event_applied = 1'b1;
                    if (i_line.verdict == VERDICT_UP) begin
                        o_mask = i_mask & ~bit_sel;
                    end else begin
                        o_mask = i_mask | bit_sel;
                    end
                end
                o_line = LINE_CLEAR;
            end
        end else if (i_line.len != LAST_POS) begin
            o_line.len = i_line.len + LEN_W'(1);
            if (i_line.matching) begin
                if (p < LEN_W'(HDR_LEN)) begin
                    if (i_byte != hdr_char(p[3:0])) begin
                        o_line.matching = 1'b0;
                    end
                end else if (p == LEN_W'(HDR_LEN)) begin
                    case (i_byte)
                        "L":     o_line.button = BTN_LEFT;
                        "C":     o_line.button = BTN_CENTER;
                        "R":     o_line.button = BTN_RIGHT;
                        default: o_line.matching = 1'b0;
                    endcase
                end else if (p < s) begin
                    if (i_byte != btn_char(i_line.button, btn_off[2:0])) begin
                        o_line.matching = 1'b0;
                    end
                end else if (p == s) begin
                    case (i_byte)
                        "D":     o_line.verdict = VERDICT_DOWN;
                        "H":     o_line.verdict = VERDICT_HELD;
                        "U":     o_line.verdict = VERDICT_UP;
                        default: o_line.matching = 1'b0;
                    endcase
                end else if ((i_line.verdict != VERDICT_NONE) &&
                             (p < s + state_len(i_line.verdict))) begin
                    if (i_byte != state_char(i_line.verdict, st_off[1:0])) begin
                        o_line.matching = 1'b0;
                    end
                end
                // bytes after the state word are ignored
            end
        end else begin
            // line full: drop the byte and the line
            o_flags.overflow = 1'b1;
            o_line = LINE_CLEAR;
        end
    end

endmodule

// File: hdl/button_event_line_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_event_line_parser
// Matches "EVT BUTTON <LEFT|CENTER|RIGHT> <DOWN|HELD|UP>" lines byte by byte
// and keeps a 3-bit pressed-button mask.
// ----------------------------------------------------------------------------
// The result is registered and is valid in the cycle after its request is accepted.
// Throughput: 1 byte per cycle while the output is not stalled; the line-state update sets it.
// Output register accepts a new request while its result is being taken.
// Reset (sync, active low): mask 0, line cleared, no result pending.
module button_event_line_parser (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [bel_pkg::IN_W-1:0]  i_s_axis_tdata,  // [7:0] rx_byte
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    // [2:0] key_state, [3] line_ended, [4] event_applied, [5] overflow, [7:6] 0
    output logic [bel_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import bel_pkg::*;

    t_line            r_line;
    logic [2:0]       r_mask;
    logic             r_valid;
    logic [OUT_W-1:0] r_data;

    t_line            n_line;
    logic [2:0]       n_mask;
    t_flags           n_flags;
    logic             accept;

    bel_match u_match (
        .i_byte  (i_s_axis_tdata),
        .i_line  (r_line),
        .i_mask  (r_mask),
        .o_line  (n_line),
        .o_mask  (n_mask),
        .o_flags (n_flags)
    );

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line  <= LINE_CLEAR;
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_line  <= n_line;
                r_mask  <= n_mask;
                r_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data <= {2'b00, n_flags.overflow, n_flags.event_applied,
                       n_flags.line_ended, n_mask};
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = r_data;

endmodule

// File: hdl/bel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bel_checker
// Port-level checks for the button event parser, bound to the top level.
// ----------------------------------------------------------------------------
module bel_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_s_axis_tvalid,
    input logic                     o_s_axis_tready,
    input logic [bel_pkg::IN_W-1:0]  i_s_axis_tdata,
    input logic                     o_m_axis_tvalid,
    input logic                     i_m_axis_tready,
    input logic [bel_pkg::OUT_W-1:0] o_m_axis_tdata
);
    import bel_pkg::*;

    // no result survives reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // an applied event always closes a line; overflow never does
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            !(o_m_axis_tdata[4] && !o_m_axis_tdata[3]) &&
            !(o_m_axis_tdata[5] && o_m_axis_tdata[3]) &&
            (o_m_axis_tdata[7:6] == 2'b00))
        else $error("inconsistent result flags");

    // a free output register must take a request
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("not ready while output empty");

    // a request accepted produces a result next cycle
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> o_m_axis_tvalid)
        else $error("accepted request gave no result");

endmodule

bind button_event_line_parser bel_checker u_bel_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
